>>> rtl/shsp_pkg.sv
// ----------------------------------------------------------------------------
// Half-step positioner package
// Field widths, register indexes and the eight-entry half-step coil table.
// ----------------------------------------------------------------------------
package shsp_pkg;

    localparam int unsigned TARGET_W  = 12;
    localparam int unsigned COIL_W    = 4;
    localparam int unsigned PHASE_W   = 3;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned CFG_IDX_W = 1;

    typedef logic [COUNT_W-1:0]   t_count;
    typedef logic [COIL_W-1:0]    t_coil;
    typedef logic [PHASE_W-1:0]   t_phase;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_STEP_PERIOD  = 1'b0;
    localparam t_cfg_idx CFG_EXCITE_TICKS = 1'b1;

    localparam t_count STEP_PERIOD_RST  = 16'd10;
    localparam t_count EXCITE_TICKS_RST = 16'd500;
    localparam t_count COUNT_MAX        = 16'hffff;

    // Coil pattern of one half-step phase, bit 0 is coil A.
    function automatic t_coil half_step_coils(input t_phase phase);
        t_coil coils;
        case (phase)
            3'd0: coils = 4'h8;
            3'd1: coils = 4'hc;
            3'd2: coils = 4'h4;
            3'd3: coils = 4'h6;
            3'd4: coils = 4'h2;
            3'd5: coils = 4'h3;
            3'd6: coils = 4'h1;
            default: coils = 4'h9;
        endcase
        return coils;
    endfunction

endpackage

>>> rtl/stepper_half_step_positioner.sv
// ----------------------------------------------------------------------------
// Stepper half-step positioner
// Drives the four coils of a unipolar stepper in half steps toward a target.
// ----------------------------------------------------------------------------
// Each item passes the input register, then the result register. Throughput:
// one item per cycle while i_stall is low, set by the single update of the
// motor state registers that each item performs.
// Reset (synchronous, active low): position, phase and counters clear, the coils
// are off, step_period returns to 10 and excite_ticks to 500, both stages empty.
module stepper_half_step_positioner #(
    parameter int unsigned POSITION_BITS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port
    input  logic                             i_cfg_we,
    input  shsp_pkg::t_cfg_idx               i_cfg_idx,
    input  shsp_pkg::t_count                 i_cfg_wdata,
    // Input channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [shsp_pkg::TARGET_W-1:0]    i_target_position,
    // Result channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [shsp_pkg::COIL_W-1:0]      o_coil_pattern,
    output logic [shsp_pkg::TARGET_W-1:0]    o_position,
    output logic                             o_moving
);

    // Configuration registers; the user writes them only while the block is idle, the block itself does not enforce it.
    shsp_pkg::t_count r_step_period;
    shsp_pkg::t_count r_excite_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_period  <= shsp_pkg::STEP_PERIOD_RST;
            r_excite_ticks <= shsp_pkg::EXCITE_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                shsp_pkg::CFG_STEP_PERIOD:  r_step_period  <= i_cfg_wdata;
                shsp_pkg::CFG_EXCITE_TICKS: r_excite_ticks <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Handshake. The input register moves into the result stage whenever the
    // result register is empty or its item is being taken this cycle; the input
    // register itself accepts a new item when it is empty or is moving on.
    logic r_in_vld;
    logic r_out_vld;
    logic out_ready;
    logic advance;
    logic in_ready;
    logic in_accept;

    assign out_ready = !r_out_vld || !i_stall;
    assign advance   = r_in_vld && out_ready;
    assign in_ready  = !r_in_vld || advance;
    assign in_accept = i_valid && in_ready;
    assign o_stall   = !in_ready;
    assign o_valid   = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_vld <= i_valid;
            end
            if (out_ready) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    // Input register holds the target of the item in flight.
    logic [shsp_pkg::TARGET_W-1:0] r_target;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_target <= i_target_position;
        end
    end

    // Motor state.
    logic [POSITION_BITS-1:0] r_position;
    shsp_pkg::t_phase         r_phase;
    shsp_pkg::t_count         r_excite_cnt;
    shsp_pkg::t_count         r_interval_cnt;
    shsp_pkg::t_coil          r_coils;

    logic [POSITION_BITS-1:0] n_position;
    shsp_pkg::t_phase         n_phase;
    shsp_pkg::t_count         n_excite_cnt;
    shsp_pkg::t_count         n_interval_cnt;
    shsp_pkg::t_coil          n_coils;

    logic [POSITION_BITS-1:0]      target;
    logic [shsp_pkg::TARGET_W-1:0] pos_field;
    shsp_pkg::t_count              excite_inc;
    shsp_pkg::t_count              interval_inc;

    // The 12-bit target is fitted to the position width: zero fill above,
    // truncation below. The position output is fitted back the same way.
    always_comb begin
        target    = '0;
        pos_field = '0;
        for (int i = 0; i < POSITION_BITS; i++) begin
            if (i < shsp_pkg::TARGET_W) begin
                target[i] = r_target[i];
            end
        end
        for (int i = 0; i < shsp_pkg::TARGET_W; i++) begin
            if (i < POSITION_BITS) begin
                pos_field[i] = n_position[i];
            end
        end
    end

    // One tick of the positioner. The excitation counter saturates, the
    // interval counter wraps. At the target the coils go off and the hold
    // starts over. Away from it, the present phase is held until the hold time
    // has elapsed; after that a half step is taken each time the interval
    // counter reaches the step period. Moving up walks the phase downward.
    always_comb begin
        excite_inc   = (r_excite_cnt == shsp_pkg::COUNT_MAX) ?
                       r_excite_cnt : r_excite_cnt + 1'b1;
        interval_inc = r_interval_cnt + 1'b1;

        n_position     = r_position;
        n_phase        = r_phase;
        n_excite_cnt   = excite_inc;
        n_interval_cnt = interval_inc;
        n_coils        = r_coils;

        if (r_position == target) begin
            n_excite_cnt = '0;
            n_coils      = '0;
        end else if (excite_inc < r_excite_ticks) begin
            n_coils        = shsp_pkg::half_step_coils(r_phase);
            n_interval_cnt = '0;
        end else if (interval_inc >= r_step_period) begin
            n_interval_cnt = '0;
            if (target > r_position) begin
                n_phase    = r_phase - 1'b1;
                n_position = r_position + 1'b1;
            end else begin
                n_phase    = r_phase + 1'b1;
                n_position = r_position - 1'b1;
            end
            n_coils = shsp_pkg::half_step_coils(n_phase);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position     <= '0;
            r_phase        <= '0;
            r_excite_cnt   <= '0;
            r_interval_cnt <= '0;
            r_coils        <= '0;
        end else if (advance) begin
            r_position     <= n_position;
            r_phase        <= n_phase;
            r_excite_cnt   <= n_excite_cnt;
            r_interval_cnt <= n_interval_cnt;
            r_coils        <= n_coils;
        end
    end

    // Result register, loaded together with the state update.
    shsp_pkg::t_coil               r_out_coils;
    logic [shsp_pkg::TARGET_W-1:0] r_out_position;
    logic                          r_out_moving;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_coils    <= n_coils;
            r_out_position <= pos_field;
            r_out_moving   <= (n_position != target);
        end
    end

    assign o_coil_pattern = r_out_coils;
    assign o_position     = r_out_position;
    assign o_moving       = r_out_moving;

endmodule

>>> tb/stepper_half_step_positioner_test.sv
// ----------------------------------------------------------------------------
// Half-step positioner testbench
// Feeds timer ticks with target positions through the valid/stall channel and
// compares every result item against a cycle-free model of the motor state.
// ----------------------------------------------------------------------------
module stepper_half_step_positioner_test;

    // Half-step coil patterns packed four bits per phase, phase 0 in the low
    // nibble: 8, c, 4, 6, 2, 3, 1, 9.
    localparam logic [31:0] PHASE_COILS = 32'h9132_64c8;

    typedef logic [shsp_pkg::TARGET_W-1:0] t_pos;

    // One expected result item: coils, position and the moving flag.
    typedef struct {
        shsp_pkg::t_coil coils;
        t_pos            pos;
        logic            moving;
    } t_motor_tick;

    // Scoreboard: carries its own copy of the motor state and the two
    // registers. Each accepted tick is turned into an expected result at once,
    // and results from the block are matched in order against that queue.
    class t_coil_predictor;
        shsp_pkg::t_count step_period;
        shsp_pkg::t_count excite_ticks;
        t_pos             cur_pos;
        shsp_pkg::t_phase phase;
        shsp_pkg::t_count excite_cnt;
        shsp_pkg::t_count interval_cnt;
        shsp_pkg::t_coil  coils;
        t_motor_tick      expected_ticks[$];
        int unsigned      errors;
        int unsigned      checked;
        int unsigned      n_steps;
        int unsigned      n_hold;
        int unsigned      n_parked;
        int unsigned      n_waiting;

        function new();
            step_period  = shsp_pkg::STEP_PERIOD_RST;
            excite_ticks = shsp_pkg::EXCITE_TICKS_RST;
            cur_pos      = '0;
            phase        = '0;
            excite_cnt   = '0;
            interval_cnt = '0;
            coils        = '0;
            errors       = 0;
            checked      = 0;
            n_steps      = 0;
            n_hold       = 0;
            n_parked     = 0;
            n_waiting    = 0;
        endfunction

        function int unsigned pending();
            return expected_ticks.size();
        endfunction

        // Advances the motor state by one tick and queues the result.
        function void accept_target(t_pos tgt);
            t_motor_tick e;
            if (excite_cnt != shsp_pkg::COUNT_MAX)
                excite_cnt = excite_cnt + 16'd1;
            interval_cnt = interval_cnt + 16'd1;
            if (cur_pos == tgt) begin
                excite_cnt = '0;
                coils      = '0;
                n_parked++;
            end else if (excite_cnt < excite_ticks) begin
                coils        = PHASE_COILS[phase*4 +: 4];
                interval_cnt = '0;
                n_hold++;
            end else if (interval_cnt >= step_period) begin
                interval_cnt = '0;
                if (tgt > cur_pos) begin
                    phase   = phase - 3'd1;
                    cur_pos = cur_pos + 12'd1;
                end else begin
                    phase   = phase + 3'd1;
                    cur_pos = cur_pos - 12'd1;
                end
                coils = PHASE_COILS[phase*4 +: 4];
                n_steps++;
            end else begin
                n_waiting++;
            end
            e.coils  = coils;
            e.pos    = cur_pos;
            e.moving = (cur_pos != tgt);
            expected_ticks.push_back(e);
        endfunction

        function void check_tick(shsp_pkg::t_coil act_coils, t_pos act_pos,
                                 logic act_moving);
            t_motor_tick e;
            if (expected_ticks.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result coils=%h pos=%0d moving=%0b",
                             act_coils, act_pos, act_moving);
                return;
            end
            e = expected_ticks.pop_front();
            checked++;
            if (act_coils !== e.coils || act_pos !== e.pos || act_moving !== e.moving) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: tick %0d expected coils=%h pos=%0d moving=%0b,",
                             checked, e.coils, e.pos, e.moving,
                             " got coils=%h pos=%0d moving=%0b",
                             act_coils, act_pos, act_moving);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    shsp_pkg::t_cfg_idx i_cfg_idx = shsp_pkg::CFG_STEP_PERIOD;
    shsp_pkg::t_count   i_cfg_wdata = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    t_pos               i_target_position = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    shsp_pkg::t_coil    o_coil_pattern;
    t_pos               o_position;
    logic               o_moving;

    t_coil_predictor    board;
    // Calm flags switch off idling on one side for a whole stretch.
    bit                 tx_calm = 1'b0;
    bit                 rx_calm = 1'b0;
    int                 stall_left = 0;
    int unsigned        n_settings = 1;

    stepper_half_step_positioner dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_target_position (i_target_position),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_coil_pattern    (o_coil_pattern),
        .o_position        (o_position),
        .o_moving          (o_moving)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Length of one idle gap, in cycles: one draw in ten takes the long range.
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Result side. Values read here at the rising edge are those from before
    // the edge, since the block and this bench both update with nonblocking
    // assignments. The stall pattern is built from random runs of stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_tick(o_coil_pattern, o_position, o_moving);
        if (!i_rst_n || rx_calm) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            i_stall <= 1'b0;
            if ($urandom_range(0, 99) < 25)
                stall_left <= gap_len();
        end
    end

    // Offers one tick item after an optional gap and returns at the edge where
    // it is taken. Valid stays high between back-to-back items.
    task automatic send_target(input t_pos tgt);
        int gap;
        gap = (tx_calm || $urandom_range(0, 99) >= 30) ? 0 : gap_len();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_target_position <= tgt;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.accept_target(tgt);
    endtask

    // Stops the sender and waits until every queued result has come back,
    // then lets the two pipeline stages empty.
    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes the step period, then the excite ticks; the block is idle here.
    task automatic set_config(input shsp_pkg::t_count period,
                              input shsp_pkg::t_count excite);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= shsp_pkg::CFG_STEP_PERIOD;
        i_cfg_wdata <= period;
        @(posedge i_clk);
        i_cfg_idx   <= shsp_pkg::CFG_EXCITE_TICKS;
        i_cfg_wdata <= excite;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.step_period  = period;
        board.excite_ticks = excite;
        n_settings++;
    endtask

    // Random traffic for one register setting. Most of it is move commands:
    // a target a short distance from where the motor will be, held for a run
    // of ticks so the hold, the wait and the stepping all play out. The rest
    // parks the motor on its own position or throws in arbitrary targets.
    task automatic run_random(input int unsigned n_items, input bit mid_drain);
        int unsigned done;
        int unsigned hold;
        int unsigned offset;
        int unsigned pick;
        int          goal;
        t_pos        tgt;
        bit          drained;
        done    = 0;
        drained = 1'b0;
        while (done < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                offset = $urandom_range(1, 24);
                if ($urandom_range(0, 1) == 1)
                    goal = int'(board.cur_pos) + int'(offset);
                else
                    goal = int'(board.cur_pos) - int'(offset);
                if (goal < 0)
                    goal = 0;
                if (goal > 4095)
                    goal = 4095;
                tgt  = t_pos'(goal);
                hold = $urandom_range(1, 60);
            end else if (pick < 85) begin
                tgt  = board.cur_pos;
                hold = $urandom_range(1, 10);
            end else begin
                tgt  = t_pos'($urandom());
                hold = $urandom_range(1, 3);
            end
            // The last run of a stretch is cut to the items that remain.
            if (hold > n_items - done)
                hold = n_items - done;
            repeat (hold) send_target(tgt);
            done += hold;
            // Let the pipeline run dry once in the middle of a stretch.
            if (mid_drain && !drained && done >= n_items / 2) begin
                drain();
                drained = 1'b1;
            end
        end
    endtask

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        shsp_pkg::t_count periods[8];
        shsp_pkg::t_count excites[8];
        int unsigned      p;
        periods = '{16'd0, 16'd1, 16'd0, 16'd2, 16'hffff, 16'd0, 16'd3, 16'd0};
        excites = '{16'd0, 16'd0, 16'd3, 16'd4, 16'd0, 16'hffff, 16'd1, 16'd0};
        board = new();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed ticks with the reset setting: parked at zero with coils
        // off, then far targets that only hold phase 0, then back to zero,
        // which clears the hold count, and a new hold toward position 1.
        tx_calm = 1'b1;
        send_target(12'd0);
        send_target(12'd0);
        send_target(12'hfff);
        send_target(12'hfff);
        send_target(12'haaa);
        send_target(12'h555);
        send_target(12'd0);
        send_target(12'd1);
        send_target(12'd1);
        drain();

        // No hold and no wait: the motor steps on every tick. Walk up to 4,
        // park there, walk back down to 0, then start toward 2.
        set_config(16'd0, 16'd0);
        tx_calm = 1'b0;
        repeat (5) send_target(12'd4);
        repeat (5) send_target(12'd0);
        send_target(12'd2);
        send_target(12'd2);
        drain();

        // Random stretches, one per register setting, with the extremes of
        // both registers among them. The last setting is drawn at random.
        for (p = 0; p < 8; p++) begin
            if (p == 7) begin
                periods[p] = shsp_pkg::t_count'($urandom_range(0, 4));
                excites[p] = shsp_pkg::t_count'($urandom_range(0, 6));
            end
            set_config(periods[p], excites[p]);
            tx_calm = (p % 3 == 1);
            rx_calm = (p % 4 == 2);
            run_random(144, p == 0);
            drain();
        end
        rx_calm = 1'b0;
        repeat (10) @(posedge i_clk);

        $display("Checked %0d ticks under %0d register settings.",
                 board.checked, n_settings);
        $display("%0d half steps, %0d hold ticks, %0d parked ticks, %0d ticks between steps.",
                 board.n_steps, board.n_hold, board.n_parked, board.n_waiting);
        if (board.errors == 0 && board.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> stepper_half_step_positioner.f
rtl/shsp_pkg.sv
rtl/stepper_half_step_positioner.sv
tb/stepper_half_step_positioner_test.sv
